// ----- design/e2c_pkg.sv -----
package e2c_pkg;

    // pipeline layout
    localparam int NSTAGE    = 19;
    localparam int OUT_STAGE = NSTAGE - 1;
    localparam int DATE_LAST = NSTAGE - 2;
    localparam int TOD_FIRST = 3;
    localparam int TOD_DONE  = 8;

    // calendar constants
    localparam logic [16:0] DAY_SECS      = 17'd86400;
    localparam logic [11:0] HOUR_SECS     = 12'd3600;
    localparam logic [5:0]  MINUTE_SECS   = 6'd60;
    localparam logic [21:0] EPOCH_A       = 22'(2440588 + 32045);
    localparam logic [17:0] QUAD_CENT     = 18'd146097;
    localparam logic [23:0] N1_BIAS       = 24'(4 * (2440588 + 32045) + 146096);
    localparam logic [10:0] QUAD_YEAR     = 11'd1461;
    localparam logic [17:0] QY_BIAS       = 18'(4 * 365);
    localparam logic [7:0]  MONTH_SPAN    = 8'd153;
    localparam logic [12:0] YEAR_BIAS     = 13'd4800;
    localparam logic [6:0]  CENTURY_YEARS = 7'd100;
    localparam logic [3:0]  MARCH_BASED   = 4'd10;

    // floor(2^W / D), W = width of the dividend; quotient is low by at most one
    localparam logic [15:0] RECIP_DAY  = 16'((64'd1 << 32) / 64'd86400);
    localparam logic [6:0]  RECIP_QC   = 7'((64'd1 << 24) / 64'd146097);
    localparam logic [7:0]  RECIP_QY   = 8'((64'd1 << 18) / 64'd1461);
    localparam logic [3:0]  RECIP_MS   = 4'((64'd1 << 11) / 64'd153);
    localparam logic [5:0]  RECIP_C    = 6'((64'd1 << 12) / 64'd100);
    localparam logic [5:0]  RECIP_H    = 6'((64'd1 << 17) / 64'd3600);
    localparam logic [6:0]  RECIP_MIN  = 7'((64'd1 << 12) / 64'd60);
    localparam logic [7:0]  BCD_RECIP  = 8'd205;

    typedef enum logic [1:0] {
        CFG_SHOW_DATE = 2'd0,
        CFG_SHOW_TIME = 2'd1
    } cfg_idx_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  cent;
        logic [6:0]  yrlo;
    } date_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    // two BCD digits of a value below 100
    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [14:0] p;
        logic [3:0]  tens;
        logic [6:0]  ones;
        p    = 15'(v) * 15'(BCD_RECIP);
        tens = p[14:11];
        ones = v - 7'({tens, 3'b000}) - 7'({tens, 1'b0});
        return {tens, ones[3:0]};
    endfunction

    // days from March 1 to the start of month m (March based)
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- design/e2c_ctl.sv -----
module e2c_ctl import e2c_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [NSTAGE-1:0] en
);

    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] v_next;

    assign en[NSTAGE-1] = !v_reg[NSTAGE-1] || m_ready;

    for (genvar k = 0; k < NSTAGE - 1; k++) begin : g_en
        assign en[k] = !v_reg[k] || en[k+1];
    end

    assign s_ready = en[0] && aresetn;
    assign m_valid = v_reg[NSTAGE-1];

    always_comb begin
        v_next[0] = en[0] ? s_valid : v_reg[0];
        for (int k = 1; k < NSTAGE; k++) begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> $countones(v_reg) == $countones($past(v_reg))
            + int'($past(s_valid && s_ready)) - int'($past(m_valid && m_ready)))
        else $error("pipeline occupancy does not match transfers");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (&v_reg) && !m_ready |-> !s_ready)
        else $error("input taken while pipeline is full and stalled");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v_reg[0])
        else $error("accepted transfer missing from first stage");
`endif

endmodule

// ----- design/e2c_date.sv -----
module e2c_date import e2c_pkg::*; (
    input  logic                 aclk,
    input  logic [DATE_LAST:0]   en,
    input  logic [31:0]          unix_seconds,
    output logic [16:0]          tod_secs,
    output date_t                date
);

    // stage 0: seconds / 86400, reciprocal product
    logic [31:0] t0_reg;
    logic [47:0] pd0_reg, pd0_next;
    assign pd0_next = 48'(unix_seconds) * 48'(RECIP_DAY);

    // stage 1: trial quotient and remainder
    logic [15:0] dq1_reg, dq1_next;
    logic [17:0] dr1_reg, dr1_next;
    assign dq1_next = pd0_reg[47:32];
    assign dr1_next = 18'(t0_reg - 32'(dq1_next) * 32'(DAY_SECS));

    // stage 2: corrected days and seconds of day
    logic        dfix2;
    logic [15:0] days2_reg, days2_next;
    logic [16:0] secs2_reg, secs2_next;
    assign dfix2      = dr1_reg >= 18'(DAY_SECS);
    assign days2_next = dq1_reg + 16'(dfix2);
    assign secs2_next = 17'(dfix2 ? dr1_reg - 18'(DAY_SECS) : dr1_reg);

    // stage 3: 4a + 146096 and its reciprocal product
    logic [23:0] n3_reg, n3_next;
    logic [30:0] p3_reg, p3_next;
    logic [15:0] days3_reg;
    assign n3_next = {6'd0, days2_reg, 2'b00} + N1_BIAS;
    assign p3_next = 31'(n3_next) * 31'(RECIP_QC);

    // stage 4
    logic [6:0]  b4_reg, b4_next;
    logic [18:0] r4_reg, r4_next;
    logic [15:0] days4_reg;
    assign b4_next = p3_reg[30:24];
    assign r4_next = 19'(n3_reg - 24'(b4_next) * 24'(QUAD_CENT));

    // stage 5: century index b
    logic [6:0]  b5_reg, b5_next;
    logic [15:0] days5_reg;
    assign b5_next = b4_reg + 7'(r4_reg >= 19'(QUAD_CENT)) - 7'd1;

    // stage 6: day within the century, c
    logic [15:0] c6_reg, c6_next;
    logic [6:0]  b6_reg;
    assign c6_next = 16'(22'(days5_reg) + EPOCH_A
                         - 22'((24'(b5_reg) * 24'(QUAD_CENT)) >> 2));

    // stage 7
    logic [17:0] n7_reg, n7_next;
    logic [25:0] p7_reg, p7_next;
    logic [15:0] c7_reg;
    logic [6:0]  b7_reg;
    assign n7_next = {c6_reg, 2'b00} + QY_BIAS;
    assign p7_next = 26'(n7_next) * 26'(RECIP_QY);

    // stage 8
    logic [7:0]  d8_reg, d8_next;
    logic [11:0] r8_reg, r8_next;
    logic [15:0] c8_reg;
    logic [6:0]  b8_reg;
    assign d8_next = p7_reg[25:18];
    assign r8_next = 12'(n7_reg - 18'(d8_next) * 18'(QUAD_YEAR));

    // stage 9: year within the century, d
    logic [6:0]  d9_reg, d9_next;
    logic [15:0] c9_reg;
    logic [6:0]  b9_reg;
    assign d9_next = 7'(d8_reg + 8'(r8_reg >= 12'(QUAD_YEAR)) - 8'd1);

    // stage 10: day of year e, biased year
    logic [8:0]  e10_reg, e10_next;
    logic [12:0] yb10_reg, yb10_next;
    assign e10_next  = 9'(c9_reg - 16'((18'(d9_reg) * 18'(QUAD_YEAR)) >> 2));
    assign yb10_next = 13'(b9_reg) * 13'(CENTURY_YEARS) + 13'(d9_reg);

    // stage 11
    logic [10:0] n11_reg, n11_next;
    logic [14:0] p11_reg, p11_next;
    logic [8:0]  e11_reg;
    logic [12:0] yb11_reg;
    assign n11_next = 11'(12'(e10_reg) * 12'd5 - 12'd3);
    assign p11_next = 15'(n11_next) * 15'(RECIP_MS);

    // stage 12
    logic [3:0]  m12_reg, m12_next;
    logic [8:0]  r12_reg, r12_next;
    logic [8:0]  e12_reg;
    logic [12:0] yb12_reg;
    assign m12_next = p11_reg[14:11];
    assign r12_next = 9'(n11_reg - 11'(m12_next) * 11'(MONTH_SPAN));

    // stage 13: March-based month m
    logic [3:0]  m13_reg, m13_next;
    logic [8:0]  e13_reg;
    logic [12:0] yb13_reg;
    assign m13_next = m12_reg + 4'(r12_reg >= 9'(MONTH_SPAN));

    // stage 14: civil year, month, day
    logic        hi14;
    logic [11:0] year14_reg, year14_next;
    logic [3:0]  month14_reg, month14_next;
    logic [4:0]  day14_reg, day14_next;
    assign hi14         = m13_reg >= MARCH_BASED;
    assign year14_next  = 12'(yb13_reg - YEAR_BIAS + 13'(hi14));
    assign month14_next = m13_reg + 4'd3 - (hi14 ? 4'd12 : 4'd0);
    assign day14_next   = 5'(e13_reg - month_start(m13_reg));

    // stage 15: year / 100
    logic [17:0] py15_reg, py15_next;
    logic [11:0] year15_reg;
    logic [3:0]  month15_reg;
    logic [4:0]  day15_reg;
    assign py15_next = 18'(year14_reg) * 18'(RECIP_C);

    // stage 16
    logic [5:0]  yq16_reg, yq16_next;
    logic [7:0]  ry16_reg, ry16_next;
    logic [11:0] year16_reg;
    logic [3:0]  month16_reg;
    logic [4:0]  day16_reg;
    assign yq16_next = py15_reg[17:12];
    assign ry16_next = 8'(year15_reg - 12'(yq16_next) * 12'(CENTURY_YEARS));

    // stage 17
    logic  yfix17;
    date_t date17_reg, date17_next;
    assign yfix17 = ry16_reg >= 8'(CENTURY_YEARS);
    assign date17_next = '{
        year:  year16_reg,
        month: month16_reg,
        day:   day16_reg,
        cent:  5'(yq16_reg + 6'(yfix17)),
        yrlo:  7'(yfix17 ? ry16_reg - 8'(CENTURY_YEARS) : ry16_reg)
    };

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            t0_reg  <= unix_seconds;
            pd0_reg <= pd0_next;
        end
        if (en[1]) begin
            dq1_reg <= dq1_next;
            dr1_reg <= dr1_next;
        end
        if (en[2]) begin
            days2_reg <= days2_next;
            secs2_reg <= secs2_next;
        end
        if (en[3]) begin
            n3_reg    <= n3_next;
            p3_reg    <= p3_next;
            days3_reg <= days2_reg;
        end
        if (en[4]) begin
            b4_reg    <= b4_next;
            r4_reg    <= r4_next;
            days4_reg <= days3_reg;
        end
        if (en[5]) begin
            b5_reg    <= b5_next;
            days5_reg <= days4_reg;
        end
        if (en[6]) begin
            c6_reg <= c6_next;
            b6_reg <= b5_reg;
        end
        if (en[7]) begin
            n7_reg <= n7_next;
            p7_reg <= p7_next;
            c7_reg <= c6_reg;
            b7_reg <= b6_reg;
        end
        if (en[8]) begin
            d8_reg <= d8_next;
            r8_reg <= r8_next;
            c8_reg <= c7_reg;
            b8_reg <= b7_reg;
        end
        if (en[9]) begin
            d9_reg <= d9_next;
            c9_reg <= c8_reg;
            b9_reg <= b8_reg;
        end
        if (en[10]) begin
            e10_reg  <= e10_next;
            yb10_reg <= yb10_next;
        end
        if (en[11]) begin
            n11_reg  <= n11_next;
            p11_reg  <= p11_next;
            e11_reg  <= e10_reg;
            yb11_reg <= yb10_reg;
        end
        if (en[12]) begin
            m12_reg  <= m12_next;
            r12_reg  <= r12_next;
            e12_reg  <= e11_reg;
            yb12_reg <= yb11_reg;
        end
        if (en[13]) begin
            m13_reg  <= m13_next;
            e13_reg  <= e12_reg;
            yb13_reg <= yb12_reg;
        end
        if (en[14]) begin
            year14_reg  <= year14_next;
            month14_reg <= month14_next;
            day14_reg   <= day14_next;
        end
        if (en[15]) begin
            py15_reg    <= py15_next;
            year15_reg  <= year14_reg;
            month15_reg <= month14_reg;
            day15_reg   <= day14_reg;
        end
        if (en[16]) begin
            yq16_reg    <= yq16_next;
            ry16_reg    <= ry16_next;
            year16_reg  <= year15_reg;
            month16_reg <= month15_reg;
            day16_reg   <= day15_reg;
        end
        if (en[17]) begin
            date17_reg <= date17_next;
        end
    end

    assign tod_secs = secs2_reg;
    assign date     = date17_reg;

endmodule

// ----- design/e2c_tod.sv -----
module e2c_tod import e2c_pkg::*; (
    input  logic                       aclk,
    input  logic [DATE_LAST:TOD_FIRST] en,
    input  logic [16:0]                secs,
    output tod_t                       tod
);

    // stage 3: secs / 3600, reciprocal product
    logic [16:0] s3_reg;
    logic [22:0] ph3_reg, ph3_next;
    assign ph3_next = 23'(secs) * 23'(RECIP_H);

    // stage 4
    logic [5:0]  h4_reg, h4_next;
    logic [12:0] rh4_reg, rh4_next;
    assign h4_next  = ph3_reg[22:17];
    assign rh4_next = 13'(s3_reg - 17'(h4_next) * 17'(HOUR_SECS));

    // stage 5: hour and seconds of hour
    logic        hfix5;
    logic [4:0]  hour5_reg, hour5_next;
    logic [11:0] rem5_reg, rem5_next;
    assign hfix5      = rh4_reg >= 13'(HOUR_SECS);
    assign hour5_next = 5'(h4_reg + 6'(hfix5));
    assign rem5_next  = 12'(hfix5 ? rh4_reg - 13'(HOUR_SECS) : rh4_reg);

    // stage 6: rem / 60
    logic [18:0] pm6_reg, pm6_next;
    logic [11:0] rem6_reg;
    logic [4:0]  hour6_reg;
    assign pm6_next = 19'(rem5_reg) * 19'(RECIP_MIN);

    // stage 7
    logic [6:0] mi7_reg, mi7_next;
    logic [6:0] rm7_reg, rm7_next;
    logic [4:0] hour7_reg;
    assign mi7_next = pm6_reg[18:12];
    assign rm7_next = 7'(rem6_reg - 12'(mi7_next) * 12'(MINUTE_SECS));

    // stage 8 onward: finished fields ride along with the date path
    logic mfix8;
    tod_t tod8_next;
    tod_t tod_pipe [DATE_LAST:TOD_DONE];
    assign mfix8 = rm7_reg >= 7'(MINUTE_SECS);
    assign tod8_next = '{
        hour:   hour7_reg,
        minute: 6'(mi7_reg + 7'(mfix8)),
        second: 6'(mfix8 ? rm7_reg - 7'(MINUTE_SECS) : rm7_reg)
    };

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            s3_reg  <= secs;
            ph3_reg <= ph3_next;
        end
        if (en[4]) begin
            h4_reg  <= h4_next;
            rh4_reg <= rh4_next;
        end
        if (en[5]) begin
            hour5_reg <= hour5_next;
            rem5_reg  <= rem5_next;
        end
        if (en[6]) begin
            pm6_reg   <= pm6_next;
            rem6_reg  <= rem5_reg;
            hour6_reg <= hour5_reg;
        end
        if (en[7]) begin
            mi7_reg   <= mi7_next;
            rm7_reg   <= rm7_next;
            hour7_reg <= hour6_reg;
        end
        if (en[TOD_DONE]) begin
            tod_pipe[TOD_DONE] <= tod8_next;
        end
        for (int k = TOD_DONE + 1; k <= DATE_LAST; k++) begin
            if (en[k]) begin
                tod_pipe[k] <= tod_pipe[k-1];
            end
        end
    end

    assign tod = tod_pipe[DATE_LAST];

endmodule

// ----- design/epoch_seconds_to_calendar_digits.sv -----
// Unix seconds to Gregorian date and UTC time of day.
//
// Input channel s_valid/s_ready carries s_unix_seconds (32-bit unsigned).
// Result channel m_valid/m_ready carries binary year, month, day_of_month,
// hour, minute, second and packed BCD words date_bcd (YYYYMMDD) and
// time_bcd (HHMMSS).
// Config channel cfg_valid/cfg_ready writes cfg_data[0] into register
// cfg_index: 0 = show_date, 1 = show_time; other indexes are dropped.
// A disabled part reads as zero. cfg_ready is always high; write only
// while the pipeline is empty.
//
// m_valid rises once the input has passed through stages 0 to 17 into
// the output register, stage 18. Throughput: one transfer per cycle;
// each of the 19 register stages can load every cycle while the output
// is not stalled.
// Reset (aresetn low, synchronous) empties the pipeline and sets both
// show bits. When m_ready is low, stages close up behind the output
// register and s_ready drops only once every stage is occupied.
module epoch_seconds_to_calendar_digits import e2c_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_unix_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [13:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day_of_month,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second,
    output logic [31:0] m_date_bcd,
    output logic [23:0] m_time_bcd,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data
);

    logic [NSTAGE-1:0] en;
    logic [16:0]       secs;
    date_t             date;
    tod_t              tod;

    logic show_date_reg;
    logic show_time_reg;

    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg;
    logic [5:0]  second_reg;
    logic [31:0] date_bcd_reg, date_bcd_next;
    logic [23:0] time_bcd_reg, time_bcd_next;

    e2c_ctl u_ctl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .en      (en)
    );

    e2c_date u_date (
        .aclk         (aclk),
        .en           (en[DATE_LAST:0]),
        .unix_seconds (s_unix_seconds),
        .tod_secs     (secs),
        .date         (date)
    );

    e2c_tod u_tod (
        .aclk (aclk),
        .en   (en[DATE_LAST:TOD_FIRST]),
        .secs (secs),
        .tod  (tod)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            show_date_reg <= 1'b1;
            show_time_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SHOW_DATE: show_date_reg <= cfg_data;
                CFG_SHOW_TIME: show_time_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign date_bcd_next = {bcd2(7'(date.cent)), bcd2(date.yrlo),
                            bcd2(7'(date.month)), bcd2(7'(date.day))};
    assign time_bcd_next = {bcd2(7'(tod.hour)), bcd2(7'(tod.minute)),
                            bcd2(7'(tod.second))};

    always_ff @(posedge aclk) begin
        if (en[OUT_STAGE]) begin
            year_reg     <= show_date_reg ? 14'(date.year) : '0;
            month_reg    <= show_date_reg ? date.month     : '0;
            day_reg      <= show_date_reg ? date.day       : '0;
            date_bcd_reg <= show_date_reg ? date_bcd_next  : '0;
            hour_reg     <= show_time_reg ? tod.hour       : '0;
            minute_reg   <= show_time_reg ? tod.minute     : '0;
            second_reg   <= show_time_reg ? tod.second     : '0;
            time_bcd_reg <= show_time_reg ? time_bcd_next  : '0;
        end
    end

    assign m_year         = year_reg;
    assign m_month        = month_reg;
    assign m_day_of_month = day_reg;
    assign m_hour         = hour_reg;
    assign m_minute       = minute_reg;
    assign m_second       = second_reg;
    assign m_date_bcd     = date_bcd_reg;
    assign m_time_bcd     = time_bcd_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import e2c_pkg::*;

    localparam int PIPE_LATENCY = 19;
    localparam int QUIET_LIMIT  = 2000;
    localparam int N_DIRECTED   = 22;
    localparam int N_PHASES     = 6;
    localparam int PHASE_ITEMS  = 100;

    localparam logic [1:0] SPARE_INDEX_LO = 2'd2;
    localparam logic [1:0] SPARE_INDEX_HI = 2'd3;

    localparam int unsigned SECS_DAY    = 86400;
    localparam int unsigned SECS_HOUR   = 3600;
    localparam int unsigned SECS_MINUTE = 60;
    localparam int unsigned EPOCH_JDN   = 2440588;
    localparam int unsigned JDN_SHIFT   = 32045;
    localparam int unsigned CENT_DAYS   = 36524;
    localparam int unsigned QCENT_DAYS  = 146097;
    localparam int unsigned YEAR_DAYS   = 365;
    localparam int unsigned QYEAR_DAYS  = 1461;
    localparam int unsigned MONTH_DAYS5 = 153;
    localparam int unsigned YEAR_SHIFT  = 4800;
    localparam int unsigned LAST_DAY    = 49710;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] date_bcd;
        logic [23:0] time_bcd;
    } calendar_t;

    typedef struct packed {
        logic [31:0] secs;
        logic        date_on;
        logic        time_on;
        logic        checked;
        calendar_t   golden;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_unix_seconds = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [13:0] m_year;
    logic [3:0]  m_month;
    logic [4:0]  m_day_of_month;
    logic [4:0]  m_hour;
    logic [5:0]  m_minute;
    logic [5:0]  m_second;
    logic [31:0] m_date_bcd;
    logic [23:0] m_time_bcd;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic        cfg_data = 1'b0;

    logic        date_on = 1'b1;
    logic        time_on = 1'b1;
    bit          sender_steady = 1'b0;
    bit          sink_steady = 1'b0;
    int          sink_hold = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;
    calendar_t   calendar_due [$];

    stim_row_t directed_rows [N_DIRECTED] = '{
        '{32'd0, 1'b1, 1'b1, 1'b1,
          '{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'h19700101, 24'h000000}},
        '{32'd86399, 1'b1, 1'b1, 1'b1,
          '{14'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, 32'h19700101, 24'h235959}},
        '{32'd86400, 1'b1, 1'b1, 1'b1,
          '{14'd1970, 4'd1, 5'd2, 5'd0, 6'd0, 6'd0, 32'h19700102, 24'h000000}},
        '{32'hFFFFFFFF, 1'b1, 1'b1, 1'b1,
          '{14'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, 32'h21060207, 24'h062815}},
        '{32'd59, 1'b1, 1'b1, 1'b0, '0},
        '{32'd3599, 1'b1, 1'b1, 1'b0, '0},
        '{32'd951782400, 1'b1, 1'b1, 1'b0, '0},
        '{32'd946684799, 1'b1, 1'b1, 1'b0, '0},
        '{32'd4107542399, 1'b1, 1'b1, 1'b0, '0},
        '{32'h7FFFFFFF, 1'b1, 1'b1, 1'b0, '0},
        '{32'h80000000, 1'b1, 1'b1, 1'b0, '0},
        '{32'h55555555, 1'b1, 1'b1, 1'b0, '0},
        '{32'hAAAAAAAA, 1'b1, 1'b1, 1'b0, '0},
        '{32'd0, 1'b0, 1'b1, 1'b1, '0},
        '{32'hFFFFFFFF, 1'b0, 1'b1, 1'b1,
          '{14'd0, 4'd0, 5'd0, 5'd6, 6'd28, 6'd15, 32'h00000000, 24'h062815}},
        '{32'd1234567890, 1'b0, 1'b1, 1'b0, '0},
        '{32'hFFFFFFFF, 1'b1, 1'b0, 1'b1,
          '{14'd2106, 4'd2, 5'd7, 5'd0, 6'd0, 6'd0, 32'h21060207, 24'h000000}},
        '{32'd86399, 1'b1, 1'b0, 1'b1,
          '{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'h19700101, 24'h000000}},
        '{32'hFFFFFFFF, 1'b0, 1'b0, 1'b1, '0},
        '{32'd1234567890, 1'b0, 1'b0, 1'b1, '0},
        '{32'd1234567890, 1'b1, 1'b1, 1'b0, '0},
        '{32'd0, 1'b1, 1'b1, 1'b1,
          '{14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 32'h19700101, 24'h000000}}
    };

    epoch_seconds_to_calendar_digits DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_unix_seconds (s_unix_seconds),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_year         (m_year),
        .m_month        (m_month),
        .m_day_of_month (m_day_of_month),
        .m_hour         (m_hour),
        .m_minute       (m_minute),
        .m_second       (m_second),
        .m_date_bcd     (m_date_bcd),
        .m_time_bcd     (m_time_bcd),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] bcd_pair(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic calendar_t forecast_calendar(input logic [31:0] secs);
        int unsigned days, a, b, c, d, e, m, yr, mo, dy, tod, hh, mi, ss;
        calendar_t r;
        r = '0;
        if (date_on) begin
            days = secs / SECS_DAY;
            a    = days + EPOCH_JDN + JDN_SHIFT;
            b    = (4 * (a + CENT_DAYS)) / QCENT_DAYS - 1;
            c    = a - (QCENT_DAYS * b) / 4;
            d    = (4 * (c + YEAR_DAYS)) / QYEAR_DAYS - 1;
            e    = c - (QYEAR_DAYS * d) / 4;
            m    = (5 * (e - 1) + 2) / MONTH_DAYS5;
            yr   = 100 * b + d - YEAR_SHIFT + m / 10;
            mo   = m + 3 - 12 * (m / 10);
            dy   = e - (MONTH_DAYS5 * m + 2) / 5;
            r.year         = 14'(yr);
            r.month        = 4'(mo);
            r.day_of_month = 5'(dy);
            r.date_bcd     = {bcd_pair((yr / 100) % 100), bcd_pair(yr % 100),
                              bcd_pair(mo), bcd_pair(dy)};
        end
        if (time_on) begin
            tod = secs % SECS_DAY;
            hh  = tod / SECS_HOUR;
            mi  = (tod % SECS_HOUR) / SECS_MINUTE;
            ss  = tod % SECS_MINUTE;
            r.hour     = 5'(hh);
            r.minute   = 6'(mi);
            r.second   = 6'(ss);
            r.time_bcd = {bcd_pair(hh), bcd_pair(mi), bcd_pair(ss)};
        end
        return r;
    endfunction

    function automatic int idle_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_seconds();
        int unsigned days;
        days = $urandom_range(0, LAST_DAY);
        case ($urandom_range(0, 5))
            0, 1:    return $urandom();
            2:       return 32'(days * SECS_DAY + $urandom_range(0, 4) - 2);
            3:       return 32'hFFFFFFFF - 32'($urandom_range(0, 200000));
            4:       return 32'($urandom_range(0, 200000));
            default: return 32'(days * SECS_DAY + SECS_DAY - 1);
        endcase
    endfunction

    task automatic flag_error(input string what);
        $display("ERROR @%0t: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic send_seconds(input logic [31:0] secs, input calendar_t want);
        int gap;
        gap = idle_gap(sender_steady);
        @(negedge aclk);
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_unix_seconds = secs;
        do @(posedge aclk); while (!s_ready);
        calendar_due.push_back(want);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (calendar_due.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SHOW_DATE: date_on = val;
            CFG_SHOW_TIME: time_on = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_mode(input logic d, input logic t);
        wait_drained();
        write_reg(SPARE_INDEX_LO, 1'($urandom_range(0, 1)));
        write_reg(CFG_SHOW_DATE, d);
        write_reg(CFG_SHOW_TIME, t);
        write_reg(SPARE_INDEX_HI, 1'($urandom_range(0, 1)));
    endtask

    // receiver backpressure
    always @(negedge aclk) begin
        if (sink_hold > 0) begin
            m_ready = 1'b0;
            sink_hold--;
        end else begin
            m_ready   = 1'b1;
            sink_hold = idle_gap(sink_steady);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin : check_result
            calendar_t want;
            if (calendar_due.size() == 0) begin
                flag_error("result transfer with nothing pending");
            end else begin
                want = calendar_due.pop_front();
                check_field("year", 32'(m_year), 32'(want.year));
                check_field("month", 32'(m_month), 32'(want.month));
                check_field("day_of_month", 32'(m_day_of_month), 32'(want.day_of_month));
                check_field("hour", 32'(m_hour), 32'(want.hour));
                check_field("minute", 32'(m_minute), 32'(want.minute));
                check_field("second", 32'(m_second), 32'(want.second));
                check_field("date_bcd", m_date_bcd, want.date_bcd);
                check_field("time_bcd", 32'(m_time_bcd), 32'(want.time_bcd));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ERROR @%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("FAIL epoch_seconds_to_calendar_digits");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [31:0] secs;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].date_on != date_on || directed_rows[i].time_on != time_on)
                set_mode(directed_rows[i].date_on, directed_rows[i].time_on);
            send_seconds(directed_rows[i].secs,
                         directed_rows[i].checked ? directed_rows[i].golden
                                                  : forecast_calendar(directed_rows[i].secs));
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            if (phase == 0)
                set_mode(1'b1, 1'b1);
            else
                set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sender_steady = ($urandom_range(0, 3) == 0);
            sink_steady   = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    wait_drained();
                secs = pick_seconds();
                send_seconds(secs, forecast_calendar(secs));
            end
        end

        wait_drained();
        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        if (calendar_due.size() != 0)
            flag_error("results still pending at end");
        if (error_count == 0)
            $display("PASS epoch_seconds_to_calendar_digits");
        else
            $display("FAIL epoch_seconds_to_calendar_digits");
        $finish;
    end

endmodule

// ----- sim.f -----
design/e2c_pkg.sv
design/e2c_ctl.sv
design/e2c_date.sv
design/e2c_tod.sv
design/epoch_seconds_to_calendar_digits.sv
tb/testbench.sv
